// ===== hw/rtl/kcq_pkg.sv =====
`timescale 1ns / 1ps
package kcq_pkg;

  // Item operation codes carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_TRAIN    = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  // Result kind carried in tuser on the output side
  localparam logic KIND_CLASS  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam int unsigned Slots     = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned CompW     = 8 + FracBits;
  localparam int unsigned SqW       = 2 * CompW;
  localparam int unsigned DistW     = SqW + 2;
  localparam int unsigned SumW      = 30;
  localparam int unsigned CntW      = 23;
  localparam int unsigned DvdW      = SumW + FracBits;
  localparam int unsigned RemW      = CntW + 1;
  localparam int unsigned BitCntW   = 6;
  localparam logic [BitCntW-1:0] DivLastBit = BitCntW'(DvdW - 1);
  localparam logic [4:0] CountReset = 5'd10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            load_cent;
    logic            search;
    logic [1:0]      step;
    logic            first;
    logic            accum;
    logic            div_start;
    logic            div_step;
    logic            emit_cls;
    logic            emit_upd;
    logic            last;
    logic            clear_sums;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/kcq_ctrl.sv =====
`timescale 1ns / 1ps
module kcq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  input  logic              in_eop_i,
  output logic              in_ready_o,
  input  kcq_pkg::status_t  status_i,
  output kcq_pkg::cmd_t     cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIST     = 8'b0000_0010,
    S_ACCUM    = 8'b0000_0100,
    S_DLOAD    = 8'b0000_1000,
    S_DIVIDE   = 8'b0001_0000,
    S_EMIT_UPD = 8'b0010_0000,
    S_EMIT_CLS = 8'b0100_0000,
    S_CLEAR    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] count_q;
  logic [kcq_pkg::IdxW-1:0] idx_q, idx_d;
  logic [1:0] step_q, step_d;
  logic [kcq_pkg::BitCntW-1:0] bit_q, bit_d;
  logic [1:0] op_q, op_d;
  logic eop_q, eop_d;
  logic [4:0] active;
  logic [kcq_pkg::IdxW-1:0] last_idx;

  // Clamp the active cluster count to 1..16
  always_comb begin
    if (count_q == 5'd0) begin
      active = 5'd1;
    end else if (count_q > 5'd16) begin
      active = 5'd16;
    end else begin
      active = count_q;
    end
  end
  assign last_idx = kcq_pkg::IdxW'(active - 5'd1);

  // Hold the cluster count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= kcq_pkg::CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence each transaction: a load writes directly, others search, then accumulate/update or emit
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    bit_d   = bit_q;
    op_d    = op_q;
    eop_d   = eop_q;
    cmd_o   = '0;
    cmd_o.idx  = idx_q;
    cmd_o.step = step_q;
    cmd_o.first = (idx_q == '0);
    cmd_o.last  = (idx_q == last_idx);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_op_i;
          eop_d  = in_eop_i;
          idx_d  = '0;
          step_d = 2'd0;
          unique case (in_op_i)
            kcq_pkg::OP_LOAD:  cmd_o.load_cent = 1'b1;
            kcq_pkg::OP_TRAIN, kcq_pkg::OP_CLASSIFY: state_d = S_DIST;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIST: begin
        cmd_o.search = 1'b1;
        if (step_q == 2'd3) begin
          step_d = 2'd0;
          if (idx_q == last_idx) begin
            state_d = (op_q == kcq_pkg::OP_TRAIN) ? S_ACCUM : S_EMIT_CLS;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        idx_d = '0;
        state_d = eop_q ? S_DLOAD : S_IDLE;
      end
      S_DLOAD: begin
        cmd_o.div_start = 1'b1;
        bit_d = '0;
        state_d = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        bit_d = bit_q + 1'b1;
        if (bit_q == kcq_pkg::DivLastBit) begin
          state_d = S_EMIT_UPD;
        end
      end
      S_EMIT_UPD: begin
        if (status_i.out_free) begin
          cmd_o.emit_upd = 1'b1;
          if (idx_q == last_idx) begin
            state_d = S_CLEAR;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_DLOAD;
          end
        end
      end
      S_EMIT_CLS: begin
        if (status_i.out_free) begin
          cmd_o.emit_cls = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_sums = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      bit_q   <= '0;
      op_q    <= '0;
      eop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      op_q    <= op_d;
      eop_q   <= eop_d;
    end
  end

endmodule

// ===== hw/rtl/kcq_dp.sv =====
`timescale 1ns / 1ps
module kcq_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_accept_i,
  input  logic [kcq_pkg::IdxW-1:0]  in_slot_i,
  input  logic [7:0]                in_red_i,
  input  logic [7:0]                in_green_i,
  input  logic [7:0]                in_blue_i,
  input  kcq_pkg::cmd_t             cmd_i,
  output kcq_pkg::status_t          status_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      out_kind_o,
  output logic [kcq_pkg::IdxW-1:0]  out_index_o,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic                      out_last_o
);

  localparam int unsigned CW = kcq_pkg::CompW;
  localparam int unsigned FB = kcq_pkg::FracBits;
  localparam logic [kcq_pkg::SumW-1:0] SumMax = '1;
  localparam logic [kcq_pkg::CntW-1:0] CntMax = '1;

  logic [2:0][CW-1:0] cent_q [kcq_pkg::Slots];
  logic [2:0][kcq_pkg::SumW-1:0] sum_q [kcq_pkg::Slots];
  logic [kcq_pkg::CntW-1:0] cnt_q [kcq_pkg::Slots];

  logic [2:0][7:0] pix_q;
  logic [kcq_pkg::SqW-1:0] sq_q;
  logic [kcq_pkg::DistW-1:0] acc_q, best_q, dist_sum;
  logic [kcq_pkg::IdxW-1:0] win_q, sum_addr;
  logic [2:0][7:0] win_rgb_q;

  logic [2:0][kcq_pkg::DvdW-1:0] dvd_q;
  logic [2:0][kcq_pkg::RemW-1:0] rem_q;
  logic [2:0][CW-1:0] quo_q;
  logic [2:0] ovf_q;
  logic [kcq_pkg::CntW-1:0] den_q;

  logic [CW-1:0] pix_s, cent_s, diff;
  logic [2:0][CW-1:0] div_res;

  logic out_valid_q;
  logic out_kind_q, out_last_q;
  logic [kcq_pkg::IdxW-1:0] out_index_q;
  logic [2:0][7:0] out_rgb_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign sum_addr = cmd_i.accum ? win_q : cmd_i.idx;

  // Select one component for this distance step
  always_comb begin
    case (cmd_i.step)
      2'd0: begin pix_s = {pix_q[0], FB'(0)}; cent_s = cent_q[cmd_i.idx][0]; end
      2'd1: begin pix_s = {pix_q[1], FB'(0)}; cent_s = cent_q[cmd_i.idx][1]; end
      default: begin pix_s = {pix_q[2], FB'(0)}; cent_s = cent_q[cmd_i.idx][2]; end
    endcase
    diff = (pix_s >= cent_s) ? (pix_s - cent_s) : (cent_s - pix_s);
    dist_sum = acc_q + kcq_pkg::DistW'(sq_q);
  end

  // Saturate quotients to the largest 8.8 value
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      div_res[k] = ovf_q[k] ? '1 : quo_q[k];
    end
  end

  // Capture pixel, square components, track the nearest centroid
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      pix_q <= {in_blue_i, in_green_i, in_red_i};
    end
    if (cmd_i.search) begin
      if (cmd_i.step != 2'd3) begin
        sq_q <= diff * diff;
      end
      acc_q <= (cmd_i.step == 2'd0) ? '0 : dist_sum;
      if (cmd_i.step == 2'd3 && (cmd_i.first || dist_sum < best_q)) begin
        best_q <= dist_sum;
        win_q  <= cmd_i.idx;
        for (int k = 0; k < 3; k++) begin
          win_rgb_q[k] <= cent_q[cmd_i.idx][k][CW-1:FB];
        end
      end
    end
  end

  // Restoring divide, one quotient bit per cycle on all three lanes
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      den_q <= (cnt_q[cmd_i.idx] == '0) ? kcq_pkg::CntW'(1) : cnt_q[cmd_i.idx];
      for (int k = 0; k < 3; k++) begin
        dvd_q[k] <= {sum_q[cmd_i.idx][k], FB'(0)};
        rem_q[k] <= '0;
        quo_q[k] <= '0;
        ovf_q[k] <= 1'b0;
      end
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        logic [kcq_pkg::RemW-1:0] sh;
        logic                     ge;
        sh = {rem_q[k][kcq_pkg::RemW-2:0], dvd_q[k][kcq_pkg::DvdW-1]};
        ge = (sh >= {1'b0, den_q});
        rem_q[k] <= ge ? (sh - {1'b0, den_q}) : sh;
        dvd_q[k] <= {dvd_q[k][kcq_pkg::DvdW-2:0], 1'b0};
        quo_q[k] <= {quo_q[k][CW-2:0], ge};
        ovf_q[k] <= ovf_q[k] | quo_q[k][CW-1];
      end
    end
  end

  // Centroid store: loads and end-of-pass updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kcq_pkg::Slots; i++) begin
        cent_q[i] <= '0;
      end
    end else if (cmd_i.load_cent) begin
      cent_q[in_slot_i] <= {{in_blue_i, FB'(0)}, {in_green_i, FB'(0)}, {in_red_i, FB'(0)}};
    end else if (cmd_i.emit_upd) begin
      cent_q[cmd_i.idx] <= div_res;
    end
  end

  // Cluster sums and counts: saturating accumulate, clear after a pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kcq_pkg::Slots; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.clear_sums) begin
      for (int i = 0; i < kcq_pkg::Slots; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.accum) begin
      for (int k = 0; k < 3; k++) begin
        logic [kcq_pkg::SumW:0] s;
        s = {1'b0, sum_q[sum_addr][k]} + (kcq_pkg::SumW + 1)'(pix_q[k]);
        sum_q[sum_addr][k] <= s[kcq_pkg::SumW] ? SumMax : s[kcq_pkg::SumW-1:0];
      end
      if (cnt_q[sum_addr] != CntMax) begin
        cnt_q[sum_addr] <= cnt_q[sum_addr] + 1'b1;
      end
    end
  end

  // Output register: hold until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_cls || cmd_i.emit_upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_cls) begin
      out_kind_q  <= kcq_pkg::KIND_CLASS;
      out_index_q <= win_q;
      out_rgb_q   <= win_rgb_q;
      out_last_q  <= 1'b1;
    end else if (cmd_i.emit_upd) begin
      out_kind_q  <= kcq_pkg::KIND_UPDATE;
      out_index_q <= cmd_i.idx;
      for (int k = 0; k < 3; k++) begin
        out_rgb_q[k] <= div_res[k][CW-1:FB];
      end
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_index_o = out_index_q;
  assign out_red_o   = out_rgb_q[0];
  assign out_green_o = out_rgb_q[1];
  assign out_blue_o  = out_rgb_q[2];
  assign out_last_o  = out_last_q;

endmodule

// ===== hw/rtl/kmeans_color_quantizer.sv =====
`timescale 1ns / 1ps
// K-means color quantizer, one Lloyd pass per streamed image.
// Input stream: tuser carries the operation (load centroid, training pixel,
// classify pixel), tlast marks the last training pixel of a pass, tdata
// carries slot and color. Output stream: tuser is the result kind
// (classification or updated centroid), tlast marks the final result of
// the input transaction. Config port cfg_we_i/cfg_wdata_i sets the number
// of active clusters N (1..16, reset 10); the user must write it only while
// idle, which the block does not enforce. One transaction is handled at a time.
// A load writes its centroid directly. Classify and training pixels run a
// nearest-centroid search (one color component squared at a time on a shared
// multiplier), then emit or accumulate. The last training pixel of a pass
// also runs, for each cluster, a bit-serial divide of sum by count for all
// three components, then writes and emits the new centroid.
// Reset clears centroids, sums, counts and the output valid flag.
// When the receiver stalls, the held result stays in the output register
// and the engine waits before emitting the next result; input is taken
// again once the current transaction has placed its last result.
module kmeans_color_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cluster_index[3:0], red[11:4], green[19:12], blue[27:20]
  input  logic        s_axis_tlast,
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // winner_index[3:0], red_out[11:4], green_out[19:12], blue_out[27:20]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // kind
);

  kcq_pkg::cmd_t    cmd;
  kcq_pkg::status_t status;
  logic [3:0] out_index;
  logic [7:0] out_red, out_green, out_blue;

  kcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_eop_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kcq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (s_axis_tvalid & s_axis_tready),
    .in_slot_i    (s_axis_tdata[3:0]),
    .in_red_i     (s_axis_tdata[11:4]),
    .in_green_i   (s_axis_tdata[19:12]),
    .in_blue_i    (s_axis_tdata[27:20]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (m_axis_tuser),
    .out_index_o  (out_index),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_blue, out_green, out_red, out_index};

endmodule
